// ===== design/page_frame_refcount_allocator_core_macros.svh =====
// Assertion macros shared by the page frame allocator RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define PFRA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("page frame allocator check failed");
`define PFRA_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("page frame allocator forbidden condition");
`else
`define PFRA_ASSERT(lbl, clk, rst_n, prop)
`define PFRA_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/pfra_pkg.sv =====
// Shared types and codes for the page frame allocator.
// Depends on nothing; used by every module of the block.
`default_nettype none
package pfra_pkg;
    localparam int IDX_W = 21;

    localparam logic [2:0] FUNC_INIT  = 3'd0;
    localparam logic [2:0] FUNC_ALLOC = 3'd1;
    localparam logic [2:0] FUNC_FREE  = 3'd2;
    localparam logic [2:0] FUNC_SHARE = 3'd3;
    localparam logic [2:0] FUNC_COW   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_BELOW    = 3'd2;
    localparam logic [2:0] ST_NOFRAME  = 3'd3;
    localparam logic [2:0] ST_FREED    = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    localparam logic [7:0] USED_MARK = 8'd100;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]       func;
        logic             below;
        logic             tracked;
        logic [31:0]      addr;
        logic [31:0]      end_addr;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] idx_hi;
    } cmd_t;
endpackage
`default_nettype wire

// ===== design/pfra_front.sv =====
// Front end: registers an incoming item and classifies its address.
// Depends on pfra_pkg.
`default_nettype none
module pfra_front #(
    parameter int NUM_FRAMES   = 4096,
    parameter int BASE_ADDRESS = 1048576,
    parameter int PAGE_SHIFT   = 12
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [2:0]   s_func,
    input  wire logic [31:0]  s_page_address,
    input  wire logic [31:0]  s_end_address,
    output logic              f_valid,
    input  wire logic         f_ready,
    output pfra_pkg::cmd_t    f_cmd
);
    import pfra_pkg::*;

    localparam logic [31:0] BASE = 32'(BASE_ADDRESS);
    localparam logic [31:0] NUMF = 32'(NUM_FRAMES);
    localparam logic [31:0] PMASK = ~((32'd1 << PAGE_SHIFT) - 32'd1);

    logic        valid_reg;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [31:0] sel_addr, sel_fidx, end_fidx;
    logic        sel_below, end_below;

    always_comb begin
        // free uses the raw address, share and copy-on-write the page-aligned one
        sel_addr  = (s_func == FUNC_FREE || s_func == FUNC_INIT) ? s_page_address
                                                                  : (s_page_address & PMASK);
        sel_below = sel_addr < BASE;
        sel_fidx  = (sel_addr - BASE) >> PAGE_SHIFT;
        end_below = s_end_address < BASE;
        end_fidx  = (s_end_address - BASE) >> PAGE_SHIFT;

        cmd_next.func     = s_func;
        cmd_next.below    = sel_below;
        cmd_next.tracked  = !sel_below && (sel_fidx < NUMF);
        cmd_next.addr     = s_page_address;
        cmd_next.end_addr = s_end_address;
        cmd_next.idx      = sel_below ? '0 :
                            (sel_fidx > NUMF) ? IDX_W'(NUMF) : IDX_W'(sel_fidx);
        cmd_next.idx_hi   = end_below ? '0 :
                            (end_fidx > NUMF) ? IDX_W'(NUMF) : IDX_W'(end_fidx);
    end

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_cmd   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_reg <= cmd_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/pfra_queue.sv =====
// Two-entry queue of classified commands between front and back.
// Depends on pfra_pkg.
`default_nettype none
module pfra_queue (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      w_valid,
    output logic           w_ready,
    input  pfra_pkg::cmd_t w_cmd,
    output logic           r_valid,
    input  wire logic      r_ready,
    output pfra_pkg::cmd_t r_cmd
);
    import pfra_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign w_ready = cnt_reg != 2'd2;
    assign r_valid = cnt_reg != 2'd0;
    assign r_cmd   = slot_reg[rd_ptr_reg];
    assign push    = w_valid && w_ready;
    assign pop     = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= w_cmd;
        end
    end
endmodule
`default_nettype wire

// ===== design/pfra_back.sv =====
// Back end: count memory, sweeps, free-frame scan and the result register.
// Depends on pfra_pkg and the assertion macro header.
`default_nettype none
`include "page_frame_refcount_allocator_core_macros.svh"
module pfra_back #(
    parameter int NUM_FRAMES   = 4096,
    parameter int BASE_ADDRESS = 1048576,
    parameter int PAGE_SHIFT   = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  pfra_pkg::cmd_t   q_cmd,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_result_address,
    output logic             m_reuse_in_place,
    output logic             m_copy_needed
);
    import pfra_pkg::*;

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [IW-1:0] LAST = IW'(NUM_FRAMES - 1);
    localparam logic [31:0]   BASE = 32'(BASE_ADDRESS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_COWW  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [7:0]    mem [NUM_FRAMES];
    logic [7:0]    rd_data_reg;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data, eff_cnt;
    logic          wr_en;

    logic [2:0]    state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [IW-1:0] sweep_reg, sweep_next, scan_reg, scan_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next, new_idx_reg, new_idx_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [7:0]    old_cnt_reg, old_cnt_next;
    logic [31:0]   high_limit_reg, high_limit_next;
    logic [2:0]    rs_status_reg, rs_status_next;
    logic [31:0]   rs_addr_reg, rs_addr_next;
    logic          rs_reuse_reg, rs_reuse_next, rs_copy_reg, rs_copy_next;
    logic          m_valid_reg;
    logic [2:0]    m_status_reg;
    logic [31:0]   m_addr_reg;
    logic          m_reuse_reg, m_copy_reg;
    logic          in_range, load_out;

    function automatic logic [31:0] frame_addr(input logic [IW-1:0] idx);
        return BASE + (32'(idx) << PAGE_SHIFT);
    endfunction

    assign q_ready  = state_reg == S_IDLE;
    assign load_out = state_reg == S_DONE && (!m_valid_reg || m_ready);
    assign in_range = (IDX_W'(sweep_reg) >= cmd_reg.idx) && (IDX_W'(sweep_reg) < cmd_reg.idx_hi);
    assign eff_cnt  = (new_idx_reg == cmd_reg.idx[IW-1:0]) ? 8'd1 : old_cnt_reg;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        sweep_next      = sweep_reg;
        scan_next       = scan_reg;
        chk_idx_next    = chk_idx_reg;
        chk_vld_next    = chk_vld_reg;
        new_idx_next    = new_idx_reg;
        old_cnt_next    = old_cnt_reg;
        high_limit_next = high_limit_reg;
        rs_status_next  = rs_status_reg;
        rs_addr_next    = rs_addr_reg;
        rs_reuse_next   = rs_reuse_reg;
        rs_copy_next    = rs_copy_reg;
        rd_addr         = scan_reg;
        wr_en           = 1'b0;
        wr_addr         = sweep_reg;
        wr_data         = USED_MARK;

        case (state_reg)
            S_CLEAR: begin
                wr_en      = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (q_valid) begin
                    cmd_next       = q_cmd;
                    rs_status_next = ST_OK;
                    rs_addr_next   = '0;
                    rs_reuse_next  = 1'b0;
                    rs_copy_next   = 1'b0;
                    rd_addr        = q_cmd.idx[IW-1:0];
                    scan_next      = LAST;
                    chk_vld_next   = 1'b0;
                    state_next     = S_DONE;
                    case (q_cmd.func)
                        FUNC_INIT: begin
                            high_limit_next = q_cmd.end_addr;
                            sweep_next      = '0;
                            state_next      = S_INIT;
                        end
                        FUNC_ALLOC: state_next = S_SCAN;
                        FUNC_FREE: begin
                            if (q_cmd.below) rs_status_next = ST_BELOW;
                            else if (q_cmd.addr >= high_limit_reg || !q_cmd.tracked)
                                rs_status_next = ST_NOFRAME;
                            else state_next = S_CHK;
                        end
                        FUNC_SHARE: begin
                            if (q_cmd.below) rs_status_next = ST_BELOW;
                            else if (!q_cmd.tracked) rs_status_next = ST_NOFRAME;
                            else state_next = S_CHK;
                        end
                        FUNC_COW: state_next = q_cmd.tracked ? S_CHK : S_SCAN;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                wr_en      = 1'b1;
                wr_data    = in_range ? 8'd0 : USED_MARK;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST) state_next = S_DONE;
            end
            S_CHK: begin
                wr_addr    = cmd_reg.idx[IW-1:0];
                state_next = S_DONE;
                case (cmd_reg.func)
                    FUNC_FREE: begin
                        if (rd_data_reg == 8'd0) rs_status_next = ST_FREED;
                        else begin
                            wr_en   = 1'b1;
                            wr_data = rd_data_reg - 8'd1;
                        end
                    end
                    FUNC_SHARE: begin
                        if (rd_data_reg == COUNT_MAX) rs_status_next = ST_OVERFLOW;
                        else begin
                            wr_en   = 1'b1;
                            wr_data = rd_data_reg + 8'd1;
                        end
                    end
                    default: begin
                        // copy-on-write: sole owner keeps its page
                        old_cnt_next = rd_data_reg;
                        if (rd_data_reg == 8'd1) rs_reuse_next = 1'b1;
                        else state_next = S_SCAN;
                    end
                endcase
            end
            S_SCAN: begin
                if (chk_vld_reg && rd_data_reg == 8'd0) begin
                    wr_en        = 1'b1;
                    wr_addr      = chk_idx_reg;
                    wr_data      = 8'd1;
                    rs_addr_next = frame_addr(chk_idx_reg);
                    new_idx_next = chk_idx_reg;
                    state_next   = S_DONE;
                    if (cmd_reg.func == FUNC_COW) begin
                        rs_copy_next = 1'b1;
                        if (cmd_reg.tracked) state_next = S_COWW;
                    end
                end else if (chk_vld_reg && chk_idx_reg == '0) begin
                    rs_status_next = ST_OOM;
                    state_next     = S_DONE;
                end else begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = scan_reg;
                    scan_next    = scan_reg - 1'b1;
                end
            end
            S_COWW: begin
                wr_addr    = cmd_reg.idx[IW-1:0];
                state_next = S_DONE;
                if (eff_cnt == 8'd0) rs_status_next = ST_FREED;
                else begin
                    wr_en   = 1'b1;
                    wr_data = eff_cnt - 8'd1;
                end
            end
            S_DONE: begin
                if (load_out) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            sweep_reg      <= '0;
            chk_vld_reg    <= 1'b0;
            high_limit_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            chk_vld_reg    <= chk_vld_next;
            high_limit_reg <= high_limit_next;
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
        cmd_reg       <= cmd_next;
        scan_reg      <= scan_next;
        chk_idx_reg   <= chk_idx_next;
        new_idx_reg   <= new_idx_next;
        old_cnt_reg   <= old_cnt_next;
        rs_status_reg <= rs_status_next;
        rs_addr_reg   <= rs_addr_next;
        rs_reuse_reg  <= rs_reuse_next;
        rs_copy_reg   <= rs_copy_next;
        if (load_out) begin
            m_status_reg <= rs_status_next;
            m_addr_reg   <= rs_addr_next;
            m_reuse_reg  <= rs_reuse_next;
            m_copy_reg   <= rs_copy_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_result_address = m_addr_reg;
    assign m_reuse_in_place = m_reuse_reg;
    assign m_copy_needed    = m_copy_reg;

    `PFRA_ASSERT(a_out_from_done, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
    `PFRA_ASSERT(a_scan_writes_one, aclk, aresetn, (state_reg == S_SCAN && wr_en) |-> wr_data == 8'd1)
    `PFRA_NEVER(a_reuse_xor_copy, aclk, aresetn, m_valid_reg && m_reuse_reg && m_copy_reg)
    `PFRA_ASSERT(a_oom_no_addr, aclk, aresetn, (m_valid_reg && m_status_reg == ST_OOM) |-> m_addr_reg == '0)
endmodule
`default_nettype wire

// ===== design/page_frame_refcount_allocator_core.sv =====
// Top level of the reference-counted page frame allocator.
// Depends on pfra_pkg, pfra_front, pfra_queue and pfra_back.
//
// Keeps an 8-bit use count for each of NUM_FRAMES page frames starting at
// BASE_ADDRESS, frame i covering BASE_ADDRESS + (i << PAGE_SHIFT). Each item
// carries one operation (init, allocate, free, share, copy-on-write resolve)
// and yields exactly one result item. The front stage registers and
// classifies an item, a two-entry queue holds it, and the back end carries
// it out against a count memory with one read port and one write port.
// After reset the back end sweeps every count to "used" before taking the
// first item. Free and share read and update the count of their frame;
// init sweeps every count once more. Allocate scans down from the highest
// frame one entry per cycle; a copy-on-write that needs a fresh frame adds
// the count check before the scan and the old-frame update after it.
// Input items keep flowing into the queue while the back end works and
// while a result waits at the output register, until the queue and the
// front register are full.
`default_nettype none
module page_frame_refcount_allocator_core #(
    parameter int NUM_FRAMES   = 4096,
    parameter int BASE_ADDRESS = 1048576,
    parameter int PAGE_SHIFT   = 12
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [31:0] s_page_address,
    input  wire logic [31:0] s_end_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_result_address,
    output logic             m_reuse_in_place,
    output logic             m_copy_needed
);
    import pfra_pkg::*;

    // classified item from the front stage, then from the queue
    logic f_valid, f_ready, q_valid, q_ready;
    cmd_t f_cmd, q_cmd;

    pfra_front #(
        .NUM_FRAMES  (NUM_FRAMES),
        .BASE_ADDRESS(BASE_ADDRESS),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_page_address(s_page_address),
        .s_end_address (s_end_address),
        .f_valid       (f_valid),
        .f_ready       (f_ready),
        .f_cmd         (f_cmd)
    );

    // decouple: hold classified items while the back end scans
    pfra_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .w_valid(f_valid),
        .w_ready(f_ready),
        .w_cmd  (f_cmd),
        .r_valid(q_valid),
        .r_ready(q_ready),
        .r_cmd  (q_cmd)
    );

    pfra_back #(
        .NUM_FRAMES  (NUM_FRAMES),
        .BASE_ADDRESS(BASE_ADDRESS),
        .PAGE_SHIFT  (PAGE_SHIFT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_cmd           (q_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_result_address(m_result_address),
        .m_reuse_in_place(m_reuse_in_place),
        .m_copy_needed   (m_copy_needed)
    );
endmodule
`default_nettype wire
